// ===== rtl/ffpa_pkg.sv =====
// Shared types, widths and codes for the first-fit partition allocator.
// No dependencies; the interface, allocator and ALU files refer to it by scoped names.
`timescale 1ns / 1ps
package ffpa_pkg;

   localparam int MAX_PARTS = 64;
   localparam int IDX_W     = $clog2(MAX_PARTS);
   localparam int CNT_W     = $clog2(MAX_PARTS + 1);
   localparam int ADDR_W    = 20;
   localparam int SIZE_W    = ADDR_W + 1;
   localparam int PID_W     = 16;
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = SIZE_W;

   localparam logic [SIZE_W-1:0] MEM_LIMIT = SIZE_W'(1) << ADDR_W;
   localparam logic [SIZE_W-1:0] TOTAL_RST = SIZE_W'(1048576);
   localparam logic [PID_W-1:0]  FIRST_PID_RST = PID_W'(1000);

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PID  = 1'd1;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic              hole;
      logic [PID_W-1:0]  pid;
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] a;
      logic [SIZE_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] res;
      logic              ge;
      logic              eq;
   } alu_rsp_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PID_W-1:0]  out_pid;
      logic [ADDR_W-1:0] out_base;
      logic [SIZE_W-1:0] out_size;
      logic              out_free;
      logic [CNT_W-1:0]  part_count;
   } result_type;

endpackage

// ===== rtl/ffpa_if.sv =====
// Request and response channel interfaces of the partition allocator.
// Depends on ffpa_pkg for field widths.
`timescale 1ns / 1ps
interface ffpa_req_if;
   logic                           valid;
   logic                           ready;
   logic [ffpa_pkg::CMD_W-1:0]     command;
   logic [ffpa_pkg::SIZE_W-1:0]    req_size;
   logic [ffpa_pkg::PID_W-1:0]     req_pid;
   logic [ffpa_pkg::IDX_W-1:0]     entry_index;

   modport source(output valid, command, req_size, req_pid, entry_index, input ready);
   modport sink(input valid, command, req_size, req_pid, entry_index, output ready);
endinterface

interface ffpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ffpa_pkg::STAT_W-1:0]    status;
   logic [ffpa_pkg::PID_W-1:0]     out_pid;
   logic [ffpa_pkg::ADDR_W-1:0]    out_base;
   logic [ffpa_pkg::SIZE_W-1:0]    out_size;
   logic                           out_free;
   logic [ffpa_pkg::CNT_W-1:0]     part_count;

   modport source(output valid, status, out_pid, out_base, out_size, out_free, part_count,
                  input ready);
   modport sink(input valid, status, out_pid, out_base, out_size, out_free, part_count,
                output ready);
endinterface

// ===== rtl/first_fit_partition_allocator.sv =====
// First-fit partition allocator: a sequencer walks the partition table in RAM,
// one entry at a time, through one shared add/compare unit.
// A bad request goes from idle straight to S_DONE; a read passes through S_READ_EV and an init
// through S_INIT; other commands take longer with each entry scanned and each entry shifted.
// One command at a time; the next beat is taken only in idle, once the last result is taken.
// Reset: synchronous; after it the S_INIT state loads entry 0 as a single hole.
`timescale 1ns / 1ps
module first_fit_partition_allocator (
   input  logic                              clock,
   input  logic                              reset,
   ffpa_req_if.sink                          req,
   ffpa_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [ffpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffpa_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int CNT_W  = ffpa_pkg::CNT_W;
   localparam int IDX_W  = ffpa_pkg::IDX_W;
   localparam int SIZE_W = ffpa_pkg::SIZE_W;
   localparam int ADDR_W = ffpa_pkg::ADDR_W;
   localparam int PID_W  = ffpa_pkg::PID_W;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_EV  = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_SPLIT_A  = 4'd6;
   localparam logic [3:0] S_SPLIT_B  = 4'd7;
   localparam logic [3:0] S_SPLIT_C  = 4'd8;
   localparam logic [3:0] S_FREE_NX  = 4'd9;
   localparam logic [3:0] S_FREE_M1  = 4'd10;
   localparam logic [3:0] S_FREE_M2  = 4'd11;
   localparam logic [3:0] S_REM_RD   = 4'd12;
   localparam logic [3:0] S_REM_WR   = 4'd13;
   localparam logic [3:0] S_READ_EV  = 4'd14;
   localparam logic [3:0] S_DONE     = 4'd15;

   logic [3:0]                   state_ff, state_in;
   logic                         boot_ff, boot_in;
   logic [ffpa_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [SIZE_W-1:0]            rsize_ff, rsize_in;
   logic [PID_W-1:0]             rpid_ff, rpid_in;
   logic [SIZE_W-1:0]            total_ff;
   logic [PID_W-1:0]             first_pid_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PID_W-1:0]             next_pid_ff, next_pid_in;
   logic [CNT_W-1:0]             i_ff, i_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic [CNT_W-1:0]             j_ff, j_in;
   logic [CNT_W-1:0]             pos_ff, pos_in;
   logic [SIZE_W-1:0]            acc_ff, acc_in;
   logic [SIZE_W-1:0]            sum_ff, sum_in;
   logic                         holes_ff, holes_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   ffpa_pkg::entry_type          ent_ff, ent_in;
   ffpa_pkg::entry_type          prev_ff, prev_in;
   logic                         prev_v_ff, prev_v_in;
   logic                         nxt_hole_ff, nxt_hole_in;
   logic [SIZE_W-1:0]            nxt_size_ff, nxt_size_in;
   logic [1:0]                   rem_ff, rem_in;
   ffpa_pkg::result_type         res_ff, res_in;
   logic                         out_valid_ff, out_valid_in;

   logic                         ram_we;
   logic [IDX_W-1:0]             ram_waddr;
   ffpa_pkg::entry_type          ram_wdata;
   logic [IDX_W-1:0]             ram_raddr;
   logic [ffpa_pkg::ENTRY_W-1:0] ram_rdata_raw;
   ffpa_pkg::entry_type          rd;

   ffpa_pkg::alu_req_type        alu_req;
   ffpa_pkg::alu_rsp_type        alu_rsp;

   logic                         accept;
   logic [CNT_W:0]               rem_end;
   logic [SIZE_W-1:0]            clip_size;

   assign rd = ram_rdata_raw;

   ffpa_ram #(
      .WIDTH(ffpa_pkg::ENTRY_W),
      .DEPTH(ffpa_pkg::MAX_PARTS)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata_raw)
   );

   ffpa_alu u_alu (
      .req(alu_req),
      .rsp(alu_rsp)
   );

   assign req.ready      = (state_ff == S_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept         = req.valid && req.ready;
   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = res_ff.status;
   assign rsp.out_pid    = res_ff.out_pid;
   assign rsp.out_base   = res_ff.out_base;
   assign rsp.out_size   = res_ff.out_size;
   assign rsp.out_free   = res_ff.out_free;
   assign rsp.part_count = res_ff.part_count;

   assign clip_size = (total_ff > ffpa_pkg::MEM_LIMIT) ? ffpa_pkg::MEM_LIMIT : total_ff;
   assign rem_end   = {1'b0, j_ff} + {{(CNT_W - 1){1'b0}}, rem_ff};

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      cmd_in       = cmd_ff;
      rsize_in     = rsize_ff;
      rpid_in      = rpid_ff;
      count_in     = count_ff;
      next_pid_in  = next_pid_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      holes_in     = holes_ff;
      base_in      = base_ff;
      ent_in       = ent_ff;
      prev_in      = prev_ff;
      prev_v_in    = prev_v_ff;
      nxt_hole_in  = nxt_hole_ff;
      nxt_size_in  = nxt_size_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = i_ff[IDX_W-1:0];

      alu_req.op = ffpa_pkg::ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_we         = 1'b1;
            ram_waddr      = '0;
            ram_wdata.hole = 1'b1;
            ram_wdata.size = clip_size;
            count_in       = CNT_W'(1);
            next_pid_in    = first_pid_ff;
            boot_in        = 1'b0;
            state_in       = boot_ff ? S_IDLE : S_DONE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req.command;
               rsize_in  = req.req_size;
               rpid_in   = req.req_pid;
               res_in    = '0;
               i_in      = '0;
               k_in      = '0;
               acc_in    = '0;
               sum_in    = '0;
               holes_in  = 1'b0;
               prev_v_in = 1'b0;
               case (req.command)
                  ffpa_pkg::CMD_ALLOC: begin
                     if (req.req_size == '0) begin
                        res_in.status = ffpa_pkg::ST_BAD;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  ffpa_pkg::CMD_FREE, ffpa_pkg::CMD_COMPACT: begin
                     state_in = S_SCAN_RD;
                  end
                  ffpa_pkg::CMD_READ: begin
                     if ({1'b0, req.entry_index} >= count_ff) begin
                        res_in.status = ffpa_pkg::ST_BAD;
                        state_in      = S_DONE;
                     end else begin
                        ram_raddr = req.entry_index;
                        state_in  = S_READ_EV;
                     end
                  end
                  ffpa_pkg::CMD_INIT: begin
                     state_in = S_INIT;
                  end
                  default: begin
                     res_in.status = ffpa_pkg::ST_BAD;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (i_ff == count_ff) begin
               // End of table without a match, or the tail of a compaction.
               case (cmd_ff)
                  ffpa_pkg::CMD_ALLOC: res_in.status = ffpa_pkg::ST_NOFIT;
                  ffpa_pkg::CMD_FREE:  res_in.status = ffpa_pkg::ST_NOTFOUND;
                  default: begin
                     if (holes_ff) begin
                        ram_we         = 1'b1;
                        ram_waddr      = k_ff[IDX_W-1:0];
                        ram_wdata.hole = 1'b1;
                        ram_wdata.base = acc_ff[ADDR_W-1:0];
                        ram_wdata.size = sum_ff;
                        count_in       = k_ff + CNT_W'(1);
                     end
                  end
               endcase
               state_in = S_DONE;
            end else begin
               ram_raddr = i_ff[IDX_W-1:0];
               state_in  = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            i_in     = i_ff + CNT_W'(1);
            state_in = S_SCAN_RD;
            case (cmd_ff)
               ffpa_pkg::CMD_ALLOC: begin
                  alu_req.op = ffpa_pkg::ALU_SUB;
                  alu_req.a  = rd.size;
                  alu_req.b  = rsize_ff;
                  if (rd.hole && alu_rsp.ge) begin
                     ent_in = rd;
                     pos_in = i_ff;
                     if (alu_rsp.eq) begin
                        ram_we          = 1'b1;
                        ram_waddr       = i_ff[IDX_W-1:0];
                        ram_wdata       = rd;
                        ram_wdata.hole  = 1'b0;
                        ram_wdata.pid   = next_pid_ff;
                        next_pid_in     = next_pid_ff + PID_W'(1);
                        res_in.out_pid  = next_pid_ff;
                        res_in.out_base = rd.base;
                        res_in.out_size = rd.size;
                        state_in        = S_DONE;
                     end else if (count_ff >= CNT_W'(ffpa_pkg::MAX_PARTS)) begin
                        res_in.status = ffpa_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        j_in     = count_ff;
                        state_in = S_SHIFT_RD;
                     end
                  end
               end
               ffpa_pkg::CMD_FREE: begin
                  if (!rd.hole && rd.pid == rpid_ff) begin
                     ent_in = rd;
                     pos_in = i_ff;
                     if (i_ff + CNT_W'(1) < count_ff) begin
                        ram_raddr = i_in[IDX_W-1:0];
                        state_in  = S_FREE_NX;
                     end else begin
                        nxt_hole_in = 1'b0;
                        state_in    = S_FREE_M1;
                     end
                  end else begin
                     prev_in   = rd;
                     prev_v_in = 1'b1;
                  end
               end
               default: begin
                  if (rd.hole) begin
                     alu_req.a = sum_ff;
                     alu_req.b = rd.size;
                     sum_in    = alu_rsp.res;
                     holes_in  = 1'b1;
                  end else begin
                     alu_req.a      = acc_ff;
                     alu_req.b      = rd.size;
                     acc_in         = alu_rsp.res;
                     ram_we         = 1'b1;
                     ram_waddr      = k_ff[IDX_W-1:0];
                     ram_wdata      = rd;
                     ram_wdata.base = acc_ff[ADDR_W-1:0];
                     k_in           = k_ff + CNT_W'(1);
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (j_ff == pos_ff + CNT_W'(1)) begin
               state_in = S_SPLIT_A;
            end else begin
               ram_raddr = j_ff[IDX_W-1:0] - IDX_W'(1);
               state_in  = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IDX_W-1:0];
            ram_wdata = rd;
            j_in      = j_ff - CNT_W'(1);
            state_in  = S_SHIFT_RD;
         end
         S_SPLIT_A: begin
            alu_req.op = ffpa_pkg::ALU_SUB;
            alu_req.a  = ent_ff.size;
            alu_req.b  = rsize_ff;
            acc_in     = alu_rsp.res;
            state_in   = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            alu_req.a      = SIZE_W'(ent_ff.base);
            alu_req.b      = rsize_ff;
            ram_we         = 1'b1;
            ram_waddr      = pos_ff[IDX_W-1:0] + IDX_W'(1);
            ram_wdata.hole = 1'b1;
            ram_wdata.base = alu_rsp.res[ADDR_W-1:0];
            ram_wdata.size = acc_ff;
            state_in       = S_SPLIT_C;
         end
         S_SPLIT_C: begin
            ram_we          = 1'b1;
            ram_waddr       = pos_ff[IDX_W-1:0];
            ram_wdata.hole  = 1'b0;
            ram_wdata.pid   = next_pid_ff;
            ram_wdata.base  = ent_ff.base;
            ram_wdata.size  = rsize_ff;
            next_pid_in     = next_pid_ff + PID_W'(1);
            count_in        = count_ff + CNT_W'(1);
            res_in.out_pid  = next_pid_ff;
            res_in.out_base = ent_ff.base;
            res_in.out_size = rsize_ff;
            state_in        = S_DONE;
         end
         S_FREE_NX: begin
            nxt_hole_in = rd.hole;
            nxt_size_in = rd.size;
            state_in    = S_FREE_M1;
         end
         S_FREE_M1: begin
            if (prev_v_ff && prev_ff.hole) begin
               alu_req.a = prev_ff.size;
               alu_req.b = ent_ff.size;
               acc_in    = alu_rsp.res;
               base_in   = prev_ff.base;
               pos_in    = pos_ff - CNT_W'(1);
            end else begin
               acc_in  = ent_ff.size;
               base_in = ent_ff.base;
            end
            rem_in   = {1'b0, prev_v_ff && prev_ff.hole} + {1'b0, nxt_hole_ff};
            state_in = S_FREE_M2;
         end
         S_FREE_M2: begin
            alu_req.a       = acc_ff;
            alu_req.b       = nxt_size_ff;
            ram_we          = 1'b1;
            ram_waddr       = pos_ff[IDX_W-1:0];
            ram_wdata.hole  = 1'b1;
            ram_wdata.base  = base_ff;
            ram_wdata.size  = nxt_hole_ff ? alu_rsp.res : acc_ff;
            res_in.out_pid  = rpid_ff;
            res_in.out_base = base_ff;
            res_in.out_size = ram_wdata.size;
            res_in.out_free = 1'b1;
            j_in            = pos_ff + CNT_W'(1);
            state_in        = (rem_ff == 2'd0) ? S_DONE : S_REM_RD;
         end
         S_REM_RD: begin
            // Close the gap left by the merged neighbors.
            if (rem_end >= {1'b0, count_ff}) begin
               count_in = count_ff - CNT_W'(rem_ff);
               state_in = S_DONE;
            end else begin
               ram_raddr = rem_end[IDX_W-1:0];
               state_in  = S_REM_WR;
            end
         end
         S_REM_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IDX_W-1:0];
            ram_wdata = rd;
            j_in      = j_ff + CNT_W'(1);
            state_in  = S_REM_RD;
         end
         S_READ_EV: begin
            res_in.out_pid  = rd.hole ? '0 : rd.pid;
            res_in.out_base = rd.base;
            res_in.out_size = rd.size;
            res_in.out_free = rd.hole;
            state_in        = S_DONE;
         end
         S_DONE: begin
            res_in.part_count = count_ff;
            out_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         boot_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
         count_ff     <= CNT_W'(1);
         next_pid_ff  <= ffpa_pkg::FIRST_PID_RST;
         total_ff     <= ffpa_pkg::TOTAL_RST;
         first_pid_ff <= ffpa_pkg::FIRST_PID_RST;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         next_pid_ff  <= next_pid_in;
         if (csr_we && csr_index == ffpa_pkg::CSR_TOTAL_SIZE) begin
            total_ff <= csr_wdata[SIZE_W-1:0];
         end
         if (csr_we && csr_index == ffpa_pkg::CSR_FIRST_PID) begin
            first_pid_ff <= csr_wdata[PID_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsize_ff    <= rsize_in;
      rpid_ff     <= rpid_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      holes_ff    <= holes_in;
      base_ff     <= base_in;
      ent_ff      <= ent_in;
      prev_ff     <= prev_in;
      prev_v_ff   <= prev_v_in;
      nxt_hole_ff <= nxt_hole_in;
      nxt_size_ff <= nxt_size_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_W'(ffpa_pkg::MAX_PARTS)))
      else $error("entry count out of range");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start a command");

   a_shift_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_WR) |-> (count_ff < CNT_W'(ffpa_pkg::MAX_PARTS)))
      else $error("split shift with a full table");

   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> out_valid_ff)
      else $error("finished command produced no result");

endmodule

// ===== rtl/ffpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/ffpa_alu.sv =====
// Shared add/subtract/compare unit used by the alloc, free and compact commands.
// Depends on ffpa_pkg for the request and response structs.
`timescale 1ns / 1ps
module ffpa_alu (
   input  ffpa_pkg::alu_req_type req,
   output ffpa_pkg::alu_rsp_type rsp
);

   logic [ffpa_pkg::SIZE_W:0] wide;

   always_comb begin
      if (req.op == ffpa_pkg::ALU_SUB) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.res = wide[ffpa_pkg::SIZE_W-1:0];
      // No borrow out of the subtraction means a >= b.
      rsp.ge  = ~wide[ffpa_pkg::SIZE_W];
      rsp.eq  = (req.a == req.b);
   end

endmodule
